@@ design/assert_macros.svh @@
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("check failed");

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

@@ design/cpog_pkg.sv @@
package cpog_pkg;

   localparam int SHIFT_W  = 12;
   localparam int COORD_W  = 22;
   localparam int BOX_W    = 14;
   localparam int POS_W    = 20;
   localparam int MAXS_W   = 11;
   localparam int RAD_W    = 9;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 20;
   localparam int SQ_W     = 24;
   localparam int DEN_W    = 20;
   localparam int NUM_W    = 40;
   localparam int SAT_IN_W = 48;

   localparam logic [CSR_AW-1:0] CSR_SPOT_COL  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_SPOT_ROW  = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_MAX_COL   = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_MAX_ROW   = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_RADIUS    = 3'd4;

   function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SAT_IN_W-1:0] v);
      logic [SAT_IN_W-COORD_W:0] top;
      top = v[SAT_IN_W-1:COORD_W-1];
      if ((&top) || !(|top)) return v[COORD_W-1:0];
      return v[SAT_IN_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
   endfunction

   function automatic logic [BOX_W-1:0] sat_box(input logic signed [SAT_IN_W-1:0] v);
      logic [SAT_IN_W-BOX_W:0] top;
      top = v[SAT_IN_W-1:BOX_W-1];
      if ((&top) || !(|top)) return v[BOX_W-1:0];
      return v[SAT_IN_W-1] ? {1'b1, {(BOX_W-1){1'b0}}} : {1'b0, {(BOX_W-1){1'b1}}};
   endfunction

endpackage

@@ design/cpog_chord.sv @@
// Pipelined floor(num*4^F/den), then integer square root; one bit per stage.
module cpog_chord import cpog_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic [NUM_W-1:0]                     num,
   input  logic [DEN_W-1:0]                     den,
   output logic [(NUM_W+2*FRAC_BITS)/2-1:0]     root
);

   localparam int WM = NUM_W + 2*FRAC_BITS;
   localparam int SW = WM / 2;

   logic [DEN_W-1:0] drem_ff [WM];
   logic [WM-1:0]    dvd_ff  [WM];
   logic [DEN_W-1:0] dden_ff [WM];

   logic [SW+1:0]    srem_ff [SW];
   logic [SW-1:0]    root_ff [SW];
   logic [WM-1:0]    sq_ff   [SW];

   // restoring divide, quotient bits shift in where dividend bits leave
   for (genvar k = 0; k < WM; k++) begin : g_div
      logic [DEN_W-1:0] rem_prev;
      logic [WM-1:0]    dvd_prev;
      logic [DEN_W-1:0] den_prev;
      logic [DEN_W:0]   sh;
      logic             ge;
      logic [DEN_W:0]   dif;
      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign dvd_prev = {num, {(2*FRAC_BITS){1'b0}}};
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = drem_ff[k-1];
         assign dvd_prev = dvd_ff[k-1];
         assign den_prev = dden_ff[k-1];
      end
      assign sh  = {rem_prev, dvd_prev[WM-1]};
      assign ge  = sh >= {1'b0, den_prev};
      assign dif = sh - {1'b0, den_prev};
      always_ff @(posedge clock) begin
         if (enable) begin
            drem_ff[k] <= ge ? dif[DEN_W-1:0] : sh[DEN_W-1:0];
            dvd_ff[k]  <= {dvd_prev[WM-2:0], ge};
            dden_ff[k] <= den_prev;
         end
      end
   end

   // digit-by-digit square root, two radicand bits per stage
   for (genvar j = 0; j < SW; j++) begin : g_sqrt
      logic [SW+1:0] rem_prev;
      logic [SW-1:0] root_prev;
      logic [WM-1:0] q_prev;
      logic [SW+3:0] sh;
      logic [SW+3:0] trial;
      logic          ge;
      logic [SW+3:0] dif;
      if (j == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign q_prev    = dvd_ff[WM-1];
      end else begin : g_next
         assign rem_prev  = srem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign q_prev    = sq_ff[j-1];
      end
      assign sh    = {rem_prev, q_prev[WM-1:WM-2]};
      assign trial = {2'b00, root_prev, 2'b01};
      assign ge    = sh >= trial;
      assign dif   = sh - trial;
      always_ff @(posedge clock) begin
         if (enable) begin
            srem_ff[j] <= ge ? dif[SW+1:0] : sh[SW+1:0];
            root_ff[j] <= {root_prev[SW-2:0], ge};
            sq_ff[j]   <= {q_prev[WM-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[SW-1];

endmodule

@@ design/circle_pair_overlap_geometry.sv @@
// Throughput: one word per cycle; the chord divide and square root are bit-per-stage pipes.
// Whole pipeline holds while the result register is full and not taken.
// Reset: synchronous; clears valid bits and configuration registers to zero, radius to 1.
module circle_pair_overlap_geometry import cpog_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_AW-1:0]          csr_index,
   input  logic [CSR_DW-1:0]          csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SHIFT_W-1:0]  req_first_col_shift,
   input  logic signed [SHIFT_W-1:0]  req_first_row_shift,
   input  logic signed [SHIFT_W-1:0]  req_second_col_shift,
   input  logic signed [SHIFT_W-1:0]  req_second_row_shift,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_overlaps,
   output logic signed [COORD_W-1:0]  rsp_mid_col,
   output logic signed [COORD_W-1:0]  rsp_mid_row,
   output logic signed [COORD_W-1:0]  rsp_far1_col,
   output logic signed [COORD_W-1:0]  rsp_far1_row,
   output logic signed [COORD_W-1:0]  rsp_far2_col,
   output logic signed [COORD_W-1:0]  rsp_far2_row,
   output logic signed [BOX_W-1:0]    rsp_box_left,
   output logic signed [BOX_W-1:0]    rsp_box_top,
   output logic signed [BOX_W-1:0]    rsp_box_right,
   output logic signed [BOX_W-1:0]    rsp_box_bottom
);

   localparam int CW = (FRAC_BITS + 16 > 24) ? FRAC_BITS + 16 : 24;
   localparam int SW = (NUM_W + 2*FRAC_BITS) / 2;
   localparam int LC = 3 * SW;

   typedef struct packed {
      logic                 ovl;
      logic                 dzero;
      logic                 neg_c;
      logic                 neg_r;
      logic signed [CW-1:0] mid_c;
      logic signed [CW-1:0] mid_r;
      logic [BOX_W-1:0]     box_l;
      logic [BOX_W-1:0]     box_t;
      logic [BOX_W-1:0]     box_r;
      logic [BOX_W-1:0]     box_b;
   } side_type;

   // configuration
   logic [POS_W-1:0]  spot_col_ff, spot_row_ff;
   logic [MAXS_W-1:0] max_col_ff, max_row_ff;
   logic [RAD_W-1:0]  radius_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spot_col_ff <= '0;
         spot_row_ff <= '0;
         max_col_ff  <= '0;
         max_row_ff  <= '0;
         radius_ff   <= RAD_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPOT_COL: spot_col_ff <= csr_wdata[POS_W-1:0];
            CSR_SPOT_ROW: spot_row_ff <= csr_wdata[POS_W-1:0];
            CSR_MAX_COL:  max_col_ff  <= csr_wdata[MAXS_W-1:0];
            CSR_MAX_ROW:  max_row_ff  <= csr_wdata[MAXS_W-1:0];
            CSR_RADIUS:   radius_ff   <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage 1: differences, squares, centres, box bounds
   logic signed [12:0]    dx_c, dy_c;
   logic signed [25:0]    dxp_c, dyp_c;
   logic signed [CW-1:0]  base_c, base_r, fl_c, fl_r, ce_c, ce_r, r_x;
   logic signed [CW-1:0]  sum_c, sum_r;
   logic signed [SHIFT_W-1:0] max_c, min_c, max_r, min_r;
   logic [2*RAD_W-1:0]    rsq_c;

   assign dx_c  = 13'(req_first_col_shift) - 13'(req_second_col_shift);
   assign dy_c  = 13'(req_first_row_shift) - 13'(req_second_row_shift);
   assign dxp_c = dx_c * dx_c;
   assign dyp_c = dy_c * dy_c;
   assign rsq_c = radius_ff * radius_ff;
   assign r_x   = CW'($signed({1'b0, radius_ff}));
   assign base_c = CW'($signed({1'b0, spot_col_ff}))
                 - (CW'($signed({1'b0, max_col_ff})) <<< FRAC_BITS);
   assign base_r = CW'($signed({1'b0, spot_row_ff}))
                 - (CW'($signed({1'b0, max_row_ff})) <<< FRAC_BITS);
   assign fl_c  = base_c >>> FRAC_BITS;
   assign fl_r  = base_r >>> FRAC_BITS;
   assign ce_c  = -((-base_c) >>> FRAC_BITS);
   assign ce_r  = -((-base_r) >>> FRAC_BITS);
   assign sum_c = CW'(req_first_col_shift) + CW'(req_second_col_shift);
   assign sum_r = CW'(req_first_row_shift) + CW'(req_second_row_shift);
   assign max_c = (req_first_col_shift > req_second_col_shift) ? req_first_col_shift
                                                               : req_second_col_shift;
   assign min_c = (req_first_col_shift > req_second_col_shift) ? req_second_col_shift
                                                               : req_first_col_shift;
   assign max_r = (req_first_row_shift > req_second_row_shift) ? req_first_row_shift
                                                               : req_second_row_shift;
   assign min_r = (req_first_row_shift > req_second_row_shift) ? req_second_row_shift
                                                               : req_first_row_shift;

   logic                 v1_ff;
   logic [SQ_W-1:0]      dxsq1_ff, dysq1_ff;
   logic [DEN_W-1:0]     fr1_ff;
   logic                 negc1_ff, negr1_ff;
   logic signed [CW-1:0] midc1_ff, midr1_ff, bxl1_ff, bxt1_ff, bxr1_ff, bxb1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dxsq1_ff <= dxp_c[SQ_W-1:0];
         dysq1_ff <= dyp_c[SQ_W-1:0];
         fr1_ff   <= {rsq_c, 2'b00};
         negc1_ff <= dy_c[12];
         negr1_ff <= !dx_c[12] && (dx_c != '0);
         midc1_ff <= base_c + (sum_c <<< (FRAC_BITS-1));
         midr1_ff <= base_r + (sum_r <<< (FRAC_BITS-1));
         bxl1_ff  <= fl_c + CW'(max_c) - r_x;
         bxt1_ff  <= fl_r + CW'(max_r) - r_x;
         bxr1_ff  <= ce_c + CW'(min_c) + r_x;
         bxb1_ff  <= ce_r + CW'(min_r) + r_x;
      end
   end

   // stage 2: distance compare, box saturation
   logic [SQ_W:0]    dsum_c;
   logic [DEN_W-1:0] diff_c;
   side_type         side2_in;

   assign dsum_c = {1'b0, dxsq1_ff} + {1'b0, dysq1_ff};
   assign diff_c = fr1_ff - dsum_c[DEN_W-1:0];

   always_comb begin
      side2_in.ovl   = dsum_c < {{(SQ_W+1-DEN_W){1'b0}}, fr1_ff};
      side2_in.dzero = (dsum_c == '0);
      side2_in.neg_c = negc1_ff;
      side2_in.neg_r = negr1_ff;
      side2_in.mid_c = midc1_ff;
      side2_in.mid_r = midr1_ff;
      side2_in.box_l = sat_box(SAT_IN_W'(bxl1_ff));
      side2_in.box_t = sat_box(SAT_IN_W'(bxt1_ff));
      side2_in.box_r = sat_box(SAT_IN_W'(bxr1_ff));
      side2_in.box_b = sat_box(SAT_IN_W'(bxb1_ff));
   end

   logic             v2_ff;
   side_type         side2_ff;
   logic [DEN_W-1:0] diff2_ff, cx2_ff, cy2_ff, den2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff <= side2_in;
         diff2_ff <= diff_c;
         cx2_ff   <= dxsq1_ff[DEN_W-1:0];
         cy2_ff   <= dysq1_ff[DEN_W-1:0];
         den2_ff  <= dsum_c[DEN_W-1:0];
      end
   end

   // stage 3: chord numerators
   logic             v3_ff;
   side_type         side3_ff;
   logic [NUM_W-1:0] ncol3_ff, nrow3_ff;
   logic [DEN_W-1:0] den3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side3_ff <= side2_ff;
         ncol3_ff <= cy2_ff * diff2_ff;
         nrow3_ff <= cx2_ff * diff2_ff;
         den3_ff  <= den2_ff;
      end
   end

   // chord magnitudes, twice the rounded value plus one under the root
   logic [SW-1:0] root_c, root_r;

   cpog_chord #(.FRAC_BITS(FRAC_BITS)) u_chord_col (
      .clock  (clock),
      .enable (adv),
      .num    (ncol3_ff),
      .den    (den3_ff),
      .root   (root_c)
   );

   cpog_chord #(.FRAC_BITS(FRAC_BITS)) u_chord_row (
      .clock  (clock),
      .enable (adv),
      .num    (nrow3_ff),
      .den    (den3_ff),
      .root   (root_r)
   );

   logic     vd_ff   [LC];
   side_type side_ff [LC];

   for (genvar i = 0; i < LC; i++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) vd_ff[i] <= 1'b0;
         else if (adv) vd_ff[i] <= (i == 0) ? v3_ff : vd_ff[(i == 0) ? 0 : i-1];
      end
      always_ff @(posedge clock) begin
         if (adv) side_ff[i] <= (i == 0) ? side3_ff : side_ff[(i == 0) ? 0 : i-1];
      end
   end

   // final stage: offsets, mirror, saturate
   side_type             sd;
   logic [SW:0]          magc_w, magr_w;
   logic signed [CW-1:0] offu_c, offu_r, off_c, off_r;
   logic signed [CW-1:0] f1c, f1r, f2c, f2r;

   assign sd     = side_ff[LC-1];
   assign magc_w = {1'b0, root_c} + (SW+1)'(1);
   assign magr_w = {1'b0, root_r} + (SW+1)'(1);
   assign offu_c = $signed(CW'(magc_w[SW:1]));
   assign offu_r = $signed(CW'(magr_w[SW:1]));
   assign off_c  = sd.dzero ? '0 : (sd.neg_c ? -offu_c : offu_c);
   assign off_r  = sd.dzero ? '0 : (sd.neg_r ? -offu_r : offu_r);
   assign f1c    = sd.mid_c + off_c;
   assign f1r    = sd.mid_r + off_r;
   assign f2c    = sd.mid_c - off_c;
   assign f2r    = sd.mid_r - off_r;

   logic               ovl_ff;
   logic [COORD_W-1:0] midc_ff, midr_ff, f1c_ff, f1r_ff, f2c_ff, f2r_ff;
   logic [BOX_W-1:0]   bl_ff, bt_ff, br_ff, bb_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= vd_ff[LC-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ovl_ff  <= sd.ovl;
         midc_ff <= sd.ovl ? sat_coord(SAT_IN_W'(sd.mid_c)) : '0;
         midr_ff <= sd.ovl ? sat_coord(SAT_IN_W'(sd.mid_r)) : '0;
         f1c_ff  <= sd.ovl ? sat_coord(SAT_IN_W'(f1c)) : '0;
         f1r_ff  <= sd.ovl ? sat_coord(SAT_IN_W'(f1r)) : '0;
         f2c_ff  <= sd.ovl ? sat_coord(SAT_IN_W'(f2c)) : '0;
         f2r_ff  <= sd.ovl ? sat_coord(SAT_IN_W'(f2r)) : '0;
         bl_ff   <= sd.ovl ? sd.box_l : '0;
         bt_ff   <= sd.ovl ? sd.box_t : '0;
         br_ff   <= sd.ovl ? sd.box_r : '0;
         bb_ff   <= sd.ovl ? sd.box_b : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_overlaps   = ovl_ff;
   assign rsp_mid_col    = midc_ff;
   assign rsp_mid_row    = midr_ff;
   assign rsp_far1_col   = f1c_ff;
   assign rsp_far1_row   = f1r_ff;
   assign rsp_far2_col   = f2c_ff;
   assign rsp_far2_row   = f2r_ff;
   assign rsp_box_left   = bl_ff;
   assign rsp_box_top    = bt_ff;
   assign rsp_box_right  = br_ff;
   assign rsp_box_bottom = bb_ff;

endmodule

@@ design/cpog_checker.sv @@
`include "assert_macros.svh"

module cpog_checker import cpog_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_overlaps,
   input logic signed [COORD_W-1:0] rsp_mid_col,
   input logic signed [COORD_W-1:0] rsp_far1_col,
   input logic signed [COORD_W-1:0] rsp_far2_row,
   input logic signed [BOX_W-1:0]   rsp_box_left,
   input logic signed [BOX_W-1:0]   rsp_box_top,
   input logic signed [BOX_W-1:0]   rsp_box_right,
   input logic signed [BOX_W-1:0]   rsp_box_bottom
);

   logic zero_word;
   logic box_ok;

   assign zero_word = rsp_mid_col == '0 && rsp_far1_col == '0 && rsp_far2_row == '0
                      && rsp_box_left == '0 && rsp_box_bottom == '0;
   assign box_ok    = rsp_box_left <= rsp_box_right && rsp_box_top <= rsp_box_bottom;

   // held result stays valid and keeps its far1 column
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_far1_col))

   // input side stalls only while the result register is blocked
   `CHK_ALWAYS(a_stall, clock, reset, req_ready == (!rsp_valid || rsp_ready))

   // no overlap gives zero mid column, far1 column, far2 row, left and bottom box
   `CHK_ALWAYS(a_zero, clock, reset, !(rsp_valid && !rsp_overlaps) || zero_word)

   // lens box is never inverted when the circles overlap
   `CHK_ALWAYS(a_box, clock, reset, !(rsp_valid && rsp_overlaps) || box_ok)

endmodule

bind circle_pair_overlap_geometry cpog_checker u_cpog_checker (.*);
